/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by ih_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising edge, off during reset
`define IH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication, sampled on the rising edge, off during reset
`define IH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on the rising edge, off during reset
`define IH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ih_pkg.sv */
// ----------------------------------------------------------------------------
// ih_pkg
// shared types and constants of the interval histogram
// ----------------------------------------------------------------------------
package ih_pkg;

  localparam int BOUND_REGS     = 7;
  localparam int BOUND_WIDTH    = 16;
  localparam int BIN_WIDTH      = 3;
  localparam int CNT_REG_WIDTH  = 3;
  localparam int CFG_ADDR_WIDTH = 5;
  localparam int APB_DATA_WIDTH = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam int NUM_BOUNDS_DEF   = 7;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 16;

  // register indices (byte address / 4)
  localparam logic [2:0] REG_BOUND_COUNT = 3'd0;
  localparam logic [2:0] REG_BOUND_0     = 3'd1;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic {
    ST_OK         = 1'b0,
    ST_BAD_BOUNDS = 1'b1
  } status_e;

  typedef logic signed [BOUND_WIDTH-1:0] bound_t;

  // classified item handed from front to back end
  typedef struct packed {
    opcode_e              op;
    logic [BIN_WIDTH-1:0] bin;
    status_e              status;
  } cls_t;

endpackage

/* rtl/ih_front.sv */
// ----------------------------------------------------------------------------
// ih_front
// classifies a transaction: boundary check and interval search for an add,
// bin clamp for a read
// ----------------------------------------------------------------------------
module ih_front #(
  parameter int NUM_BOUNDS   = ih_pkg::NUM_BOUNDS_DEF,
  parameter int SAMPLE_WIDTH = ih_pkg::SAMPLE_WIDTH_DEF
) (
  input  ih_pkg::opcode_e                     opcode_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_i,
  input  logic [ih_pkg::BIN_WIDTH-1:0]        bin_select_i,
  input  logic [ih_pkg::CNT_REG_WIDTH-1:0]    bound_count_i,
  input  ih_pkg::bound_t                      bounds_i [ih_pkg::BOUND_REGS],
  output ih_pkg::cls_t                        cls_o
);

  localparam int CMP_W = (SAMPLE_WIDTH > ih_pkg::BOUND_WIDTH) ? SAMPLE_WIDTH
                                                              : ih_pkg::BOUND_WIDTH;
  localparam logic [ih_pkg::BIN_WIDTH-1:0] OUTSIDE = ih_pkg::BIN_WIDTH'(NUM_BOUNDS - 1);
  localparam logic [ih_pkg::CNT_REG_WIDTH-1:0] N_MAX = ih_pkg::CNT_REG_WIDTH'(NUM_BOUNDS);
  localparam logic [ih_pkg::CNT_REG_WIDTH-1:0] N_MIN = ih_pkg::CNT_REG_WIDTH'(2);

  logic signed [CMP_W-1:0]             s_ext;
  logic signed [CMP_W-1:0]             b_ext [NUM_BOUNDS];
  logic [ih_pkg::CNT_REG_WIDTH-1:0]    n_use;
  logic                                bad;
  logic                                found;
  logic [ih_pkg::BIN_WIDTH-1:0]        hit;

  assign s_ext = CMP_W'(sample_i);

  for (genvar g = 0; g < NUM_BOUNDS; g++) begin : g_bext
    assign b_ext[g] = CMP_W'(bounds_i[g]);
  end

  always_comb begin
    if (bound_count_i < N_MIN) begin
      n_use = N_MIN;
    end else if (bound_count_i > N_MAX) begin
      n_use = N_MAX;
    end else begin
      n_use = bound_count_i;
    end
  end

  // parallel compares, first matching interval wins
  always_comb begin
    bad   = 1'b0;
    found = 1'b0;
    hit   = OUTSIDE;
    for (int j = 0; j < NUM_BOUNDS - 1; j++) begin
      if (ih_pkg::CNT_REG_WIDTH'(j + 1) < n_use) begin
        if (b_ext[j+1] <= b_ext[j]) begin
          bad = 1'b1;
        end
        if (!found && (s_ext >= b_ext[j]) && (s_ext < b_ext[j+1])) begin
          found = 1'b1;
          hit   = ih_pkg::BIN_WIDTH'(j);
        end
      end
    end
  end

  always_comb begin
    cls_o.op     = opcode_i;
    cls_o.status = ih_pkg::ST_OK;
    if (opcode_i == ih_pkg::OP_READ) begin
      cls_o.bin = (bin_select_i > OUTSIDE) ? OUTSIDE : bin_select_i;
    end else if (bad) begin
      cls_o.bin    = '0;
      cls_o.status = ih_pkg::ST_BAD_BOUNDS;
    end else begin
      cls_o.bin = hit;
    end
  end

endmodule

/* rtl/ih_queue.sv */
// ----------------------------------------------------------------------------
// ih_queue
// short fifo of classified transactions between front and back end
// ----------------------------------------------------------------------------
module ih_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ih_pkg::cls_t  push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ih_pkg::cls_t  pop_data_o
);

  localparam int PTR_W = (ih_pkg::QUEUE_DEPTH > 1) ? $clog2(ih_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ih_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(ih_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(ih_pkg::QUEUE_DEPTH);

  ih_pkg::cls_t      mem_q [ih_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (cnt_q == FULL);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/ih_back.sv */
// ----------------------------------------------------------------------------
// ih_back
// bin count registers, saturating update and result register
// ----------------------------------------------------------------------------
module ih_back #(
  parameter int NUM_BOUNDS  = ih_pkg::NUM_BOUNDS_DEF,
  parameter int COUNT_WIDTH = ih_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cls_valid_i,
  input  ih_pkg::cls_t                  cls_i,
  output logic                          cls_pop_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [ih_pkg::BIN_WIDTH-1:0]  res_bin_o,
  output logic [COUNT_WIDTH-1:0]        res_count_o,
  output ih_pkg::status_e               res_status_o
);

  localparam int IDX_W = $clog2(NUM_BOUNDS);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  logic [COUNT_WIDTH-1:0]        counts_q [NUM_BOUNDS];
  logic [IDX_W-1:0]              idx;
  logic [COUNT_WIDTH-1:0]        cur;
  logic [COUNT_WIDTH-1:0]        inc;
  logic                          valid_q;
  logic [ih_pkg::BIN_WIDTH-1:0]  bin_q;
  logic [COUNT_WIDTH-1:0]        count_q;
  ih_pkg::status_e               status_q;
  logic                          do_add;

  assign cls_pop_o = cls_valid_i && (!valid_q || res_ready_i);
  assign idx       = cls_i.bin[IDX_W-1:0];
  assign cur       = counts_q[idx];
  assign inc       = (cur == CMAX) ? cur : cur + COUNT_WIDTH'(1);
  assign do_add    = cls_pop_o && (cls_i.op == ih_pkg::OP_ADD)
                     && (cls_i.status == ih_pkg::ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        counts_q[i] <= '0;
      end
    end else if (do_add) begin
      counts_q[idx] <= inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cls_pop_o) begin
      valid_q <= 1'b1;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cls_pop_o) begin
      bin_q    <= cls_i.bin;
      status_q <= cls_i.status;
      if (cls_i.status == ih_pkg::ST_BAD_BOUNDS) begin
        count_q <= '0;
      end else if (cls_i.op == ih_pkg::OP_READ) begin
        count_q <= cur;
      end else begin
        count_q <= inc;
      end
    end
  end

  assign res_valid_o  = valid_q;
  assign res_bin_o    = bin_q;
  assign res_count_o  = count_q;
  assign res_status_o = status_q;

endmodule

/* rtl/interval_histogram.sv */
// ----------------------------------------------------------------------------
// interval_histogram
// signed sample histogram over configurable boundary intervals
// ----------------------------------------------------------------------------
// Sustains one transaction per clock in both directions while the output is
// not back-pressured. A transaction is classified in the cycle it is accepted
// (all boundary compares in parallel) and written into a two-entry queue; the
// bin count register update and the result register follow when it is popped.
// The single read-modify-write of the count registers sets the rate. Input
// tready drops only when the queue is full under output back-pressure. Counts
// clear at reset, with no clearing pass. Boundary and bound count registers are
// written over the APB port; the user must do so only while no transaction is
// in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module interval_histogram #(
  parameter int NUM_BOUNDS   = ih_pkg::NUM_BOUNDS_DEF,
  parameter int SAMPLE_WIDTH = ih_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = ih_pkg::COUNT_WIDTH_DEF,
  localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + ih_pkg::BIN_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((COUNT_WIDTH + ih_pkg::BIN_WIDTH + 7) / 8) * 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // apb configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ih_pkg::CFG_ADDR_WIDTH-1:0]    paddr,
  input  logic [ih_pkg::APB_DATA_WIDTH-1:0]    pwdata,
  output logic [ih_pkg::APB_DATA_WIDTH-1:0]    prdata,
  output logic                                 pready,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [IN_TDATA_W-1:0]                s_axis_tdata,  // sample, bin_select
  input  logic [0:0]                           s_axis_tuser,  // opcode
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [OUT_TDATA_W-1:0]               m_axis_tdata,  // bin, count
  output logic [0:0]                           m_axis_tuser   // status
);

  localparam int BW = ih_pkg::BIN_WIDTH;

  logic [ih_pkg::CNT_REG_WIDTH-1:0]  bound_count_q;
  ih_pkg::bound_t                    bounds_q [ih_pkg::BOUND_REGS];
  logic [2:0]                        reg_idx;
  logic [2:0]                        bnd_idx;
  logic                              cfg_wr;

  ih_pkg::cls_t                      cls_front;
  ih_pkg::cls_t                      cls_queue;
  logic                              q_full;
  logic                              q_valid;
  logic                              q_pop;
  logic                              in_acc;
  logic [BW-1:0]                     res_bin;
  logic [COUNT_WIDTH-1:0]            res_count;
  ih_pkg::status_e                   res_status;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[ih_pkg::CFG_ADDR_WIDTH-1:2];
  assign bnd_idx = reg_idx - ih_pkg::REG_BOUND_0;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_count_q <= ih_pkg::CNT_REG_WIDTH'(2);
      for (int i = 0; i < ih_pkg::BOUND_REGS; i++) begin
        bounds_q[i] <= ih_pkg::BOUND_WIDTH'(i);
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        ih_pkg::REG_BOUND_COUNT: begin
          bound_count_q <= pwdata[ih_pkg::CNT_REG_WIDTH-1:0];
        end
        default: begin
          bounds_q[bnd_idx] <= pwdata[ih_pkg::BOUND_WIDTH-1:0];
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ih_pkg::REG_BOUND_COUNT: begin
        prdata = ih_pkg::APB_DATA_WIDTH'(bound_count_q);
      end
      default: begin
        prdata = ih_pkg::APB_DATA_WIDTH'(unsigned'(bounds_q[bnd_idx]));
      end
    endcase
  end

  // front end
  assign s_axis_tready = !q_full;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  ih_front #(
    .NUM_BOUNDS   (NUM_BOUNDS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .opcode_i      (ih_pkg::opcode_e'(s_axis_tuser[0])),
    .sample_i      (signed'(s_axis_tdata[SAMPLE_WIDTH-1:0])),
    .bin_select_i  (s_axis_tdata[SAMPLE_WIDTH +: BW]),
    .bound_count_i (bound_count_q),
    .bounds_i      (bounds_q),
    .cls_o         (cls_front)
  );

  ih_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .push_data_i (cls_front),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (cls_queue)
  );

  // back end
  ih_back #(
    .NUM_BOUNDS  (NUM_BOUNDS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cls_valid_i  (q_valid),
    .cls_i        (cls_queue),
    .cls_pop_o    (q_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_bin_o    (res_bin),
    .res_count_o  (res_count),
    .res_status_o (res_status)
  );

  assign m_axis_tdata = OUT_TDATA_W'({res_count, res_bin});
  assign m_axis_tuser = res_status;

endmodule

/* rtl/ih_checker.sv */
// ----------------------------------------------------------------------------
// ih_checker
// port-level checks on the interval histogram result stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ih_checker #(
  parameter int NUM_BOUNDS  = ih_pkg::NUM_BOUNDS_DEF,
  parameter int COUNT_WIDTH = ih_pkg::COUNT_WIDTH_DEF,
  localparam int OUT_TDATA_W = ((COUNT_WIDTH + ih_pkg::BIN_WIDTH + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic [0:0]              m_axis_tuser
);

  localparam logic [ih_pkg::BIN_WIDTH-1:0] OUTSIDE =
    ih_pkg::BIN_WIDTH'(NUM_BOUNDS - 1);

  // stalled result holds
  `IH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // refused add reports bin zero and count zero
  `IH_ASSERT_IMPL(a_refused_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser[0] == ih_pkg::ST_BAD_BOUNDS), m_axis_tdata == '0, "refused add with non-zero payload")

  // bin never beyond the outside bin
  `IH_ASSERT_IMPL(a_bin_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[ih_pkg::BIN_WIDTH-1:0] <= OUTSIDE, "bin out of range")

endmodule

bind interval_histogram ih_checker #(
  .NUM_BOUNDS  (NUM_BOUNDS),
  .COUNT_WIDTH (COUNT_WIDTH)
) u_ih_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
